// File: design/tqwd_pkg.sv
// Shared types, constants and the control program of the two-queue dispatcher.
package tqwd_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 64;

    localparam logic [7:0] PRIORITY_CODE = 8'h43;

    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PPG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GPT = 1'b1;

    localparam logic [3:0] PPG_RESET = 4'd4;
    localparam logic [2:0] GPT_RESET = 3'd2;
    localparam logic [3:0] PPG_MAX   = 4'd8;
    localparam logic [2:0] GPT_MAX   = 3'd4;

    localparam logic FUNC_BOOK     = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    localparam logic [1:0] KIND_VEHICLE = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;

    typedef struct packed {
        logic       func;
        logic [7:0] vehicle_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] vehicle_code_res;
        logic       last;
    } out_item_t;

    // Datapath actions selected by the control word.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_FETCH,
        ACT_BOOK,
        ACT_DINIT,
        ACT_SLOT,
        ACT_MARK
    } act_t;

    // Jump conditions; when the condition is false the step counter advances by one.
    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_IDLE,
        JMP_IF_DISPATCH,
        JMP_IF_MORE
    } cond_t;

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_FETCH  = 3'd0;
    localparam upc_t UPC_DECODE = 3'd1;
    localparam upc_t UPC_BOOK   = 3'd2;
    localparam upc_t UPC_DINIT  = 3'd3;
    localparam upc_t UPC_SLOT   = 3'd4;
    localparam upc_t UPC_MARK   = 3'd5;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    // Status returned by the datapath to the sequencer.
    typedef struct packed {
        logic idle;      // no word accepted this cycle
        logic dispatch;  // latched word is a dispatch request
        logic more;      // batch still has slots to serve
        logic hold;      // result register busy, step must repeat
    } dp_status_t;

    function automatic ucode_t ucode_rom(input upc_t upc);
        ucode_t cw;
        unique case (upc)
            UPC_FETCH:  cw = '{act: ACT_FETCH, cond: JMP_IF_IDLE,     target: UPC_FETCH};
            UPC_DECODE: cw = '{act: ACT_NONE,  cond: JMP_IF_DISPATCH, target: UPC_DINIT};
            UPC_BOOK:   cw = '{act: ACT_BOOK,  cond: JMP_ALWAYS,      target: UPC_FETCH};
            UPC_DINIT:  cw = '{act: ACT_DINIT, cond: JMP_NEXT,        target: UPC_SLOT};
            UPC_SLOT:   cw = '{act: ACT_SLOT,  cond: JMP_IF_MORE,     target: UPC_SLOT};
            UPC_MARK:   cw = '{act: ACT_MARK,  cond: JMP_ALWAYS,      target: UPC_FETCH};
            default:    cw = '{act: ACT_NONE,  cond: JMP_ALWAYS,      target: UPC_FETCH};
        endcase
        return cw;
    endfunction

endpackage

// File: design/tqwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tqwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tqwd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: design/tqwd_sequencer.sv
// Step counter and control-word table that drive the dispatcher datapath.
module tqwd_sequencer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tqwd_pkg::dp_status_t   status,
    output tqwd_pkg::act_t         act
);

    tqwd_pkg::upc_t   upc_reg;
    tqwd_pkg::upc_t   upc_next;
    tqwd_pkg::ucode_t cw;
    logic             jump;

    assign cw  = tqwd_pkg::ucode_rom(upc_reg);
    assign act = cw.act;

    always_comb begin
        unique case (cw.cond)
            tqwd_pkg::JMP_NEXT:        jump = 1'b0;
            tqwd_pkg::JMP_ALWAYS:      jump = 1'b1;
            tqwd_pkg::JMP_IF_IDLE:     jump = status.idle;
            tqwd_pkg::JMP_IF_DISPATCH: jump = status.dispatch;
            tqwd_pkg::JMP_IF_MORE:     jump = status.more;
            default:                   jump = 1'b1;
        endcase
    end

    always_comb begin
        if (status.hold) begin
            upc_next = upc_reg;
        end else if (jump) begin
            upc_next = cw.target;
        end else begin
            upc_next = upc_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= tqwd_pkg::UPC_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: design/tqwd_datapath.sv
// Queue state, slot counters and result register of the dispatcher.
module tqwd_datapath #(
    parameter int QUEUE_DEPTH = tqwd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tqwd_pkg::act_t                      act,
    output tqwd_pkg::dp_status_t                status,
    input  logic                                cfg_wr_en,
    input  logic [tqwd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tqwd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tqwd_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tqwd_pkg::out_item_t                 m_item
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [3:0]          ppg_reg;
    logic [2:0]          gpt_reg;
    tqwd_pkg::in_item_t  item_reg;
    logic [CNT_W-1:0]    pri_cnt_reg, pri_cnt_next;
    logic [CNT_W-1:0]    sec_cnt_reg, sec_cnt_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [3:0]          slot_reg, slot_next;
    logic [1:0]          group_reg, group_next;
    logic                served_reg, served_next;
    logic                m_valid_reg, m_valid_next;
    tqwd_pkg::out_item_t m_item_reg, m_item_next;

    logic [3:0] ppg_eff;
    logic [2:0] gpt_eff;
    logic       accepted;
    logic       out_free;
    logic       emit;
    logic       hold;
    logic       done;
    logic       ram_wr;
    logic [7:0] ram_rdata;
    logic       is_prio_code;
    logic       drop;
    logic       prefer;
    logic       take_pri;
    logic       take_sec;
    logic       final_slot;

    // Out-of-range register values saturate into the legal range.
    always_comb begin
        if (ppg_reg == 4'd0) begin
            ppg_eff = 4'd1;
        end else if (ppg_reg > tqwd_pkg::PPG_MAX) begin
            ppg_eff = tqwd_pkg::PPG_MAX;
        end else begin
            ppg_eff = ppg_reg;
        end
        if (gpt_reg == 3'd0) begin
            gpt_eff = 3'd1;
        end else if (gpt_reg > tqwd_pkg::GPT_MAX) begin
            gpt_eff = tqwd_pkg::GPT_MAX;
        end else begin
            gpt_eff = gpt_reg;
        end
    end

    assign s_ready  = (act == tqwd_pkg::ACT_FETCH);
    assign accepted = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign is_prio_code = (item_reg.vehicle_code == tqwd_pkg::PRIORITY_CODE);
    assign drop = is_prio_code ? (pri_cnt_reg == FULL_CNT) : (sec_cnt_reg == FULL_CNT);

    // A slot prefers the priority class until its share of the group is used.
    assign prefer   = (slot_reg < ppg_eff);
    assign take_pri = (prefer && pri_cnt_reg != '0) || (sec_cnt_reg == '0 && pri_cnt_reg != '0);
    assign take_sec = !take_pri && (sec_cnt_reg != '0);
    assign final_slot = ({1'b0, group_reg} == gpt_eff - 3'd1) && (slot_reg == ppg_eff);

    always_comb begin
        pri_cnt_next = pri_cnt_reg;
        sec_cnt_next = sec_cnt_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        slot_next    = slot_reg;
        group_next   = group_reg;
        served_next  = served_reg;
        m_item_next  = m_item_reg;
        ram_wr       = 1'b0;
        emit         = 1'b0;
        done         = 1'b1;

        unique case (act)
            tqwd_pkg::ACT_BOOK: begin
                emit = drop;
                m_item_next = '{kind: tqwd_pkg::KIND_DROPPED,
                                vehicle_code_res: item_reg.vehicle_code, last: 1'b1};
                if (!drop) begin
                    if (is_prio_code) begin
                        pri_cnt_next = pri_cnt_reg + CNT_W'(1);
                    end else begin
                        ram_wr       = 1'b1;
                        tail_next    = (tail_reg == LAST_PTR) ? '0 : tail_reg + PTR_W'(1);
                        sec_cnt_next = sec_cnt_reg + CNT_W'(1);
                    end
                end
            end
            tqwd_pkg::ACT_DINIT: begin
                slot_next   = 4'd0;
                group_next  = 2'd0;
                served_next = 1'b0;
            end
            tqwd_pkg::ACT_SLOT: begin
                emit = take_pri || take_sec;
                if (take_pri) begin
                    pri_cnt_next = pri_cnt_reg - CNT_W'(1);
                end
                if (take_sec) begin
                    sec_cnt_next = sec_cnt_reg - CNT_W'(1);
                    head_next    = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
                end
                // Counts only fall during a batch, so two empty queues end it for good.
                done = final_slot || (pri_cnt_next == '0 && sec_cnt_next == '0);
                m_item_next = '{kind: tqwd_pkg::KIND_VEHICLE,
                                vehicle_code_res: take_pri ? tqwd_pkg::PRIORITY_CODE : ram_rdata,
                                last: done};
                if (emit) begin
                    served_next = 1'b1;
                end
                if (slot_reg == ppg_eff) begin
                    slot_next  = 4'd0;
                    group_next = group_reg + 2'd1;
                end else begin
                    slot_next = slot_reg + 4'd1;
                end
            end
            tqwd_pkg::ACT_MARK: begin
                emit = !served_reg;
                m_item_next = '{kind: tqwd_pkg::KIND_EMPTY, vehicle_code_res: 8'h00, last: 1'b1};
            end
            default: begin
            end
        endcase

        hold = emit && !out_free;

        // A stalled step changes nothing and is repeated.
        if (hold) begin
            pri_cnt_next = pri_cnt_reg;
            sec_cnt_next = sec_cnt_reg;
            head_next    = head_reg;
            tail_next    = tail_reg;
            slot_next    = slot_reg;
            group_next   = group_reg;
            served_next  = served_reg;
            m_item_next  = m_item_reg;
            ram_wr       = 1'b0;
        end else if (!emit) begin
            m_item_next = m_item_reg;
        end

        m_valid_next = out_free ? (emit && !hold) : m_valid_reg;
    end

    assign status = '{idle: !accepted,
                      dispatch: (item_reg.func == tqwd_pkg::FUNC_DISPATCH),
                      more: !done,
                      hold: hold};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppg_reg     <= tqwd_pkg::PPG_RESET;
            gpt_reg     <= tqwd_pkg::GPT_RESET;
            pri_cnt_reg <= '0;
            sec_cnt_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            slot_reg    <= 4'd0;
            group_reg   <= 2'd0;
            served_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == tqwd_pkg::REG_PPG) begin
                    ppg_reg <= cfg_wdata[3:0];
                end else if (cfg_index == tqwd_pkg::REG_GPT) begin
                    gpt_reg <= cfg_wdata[2:0];
                end
            end
            pri_cnt_reg <= pri_cnt_next;
            sec_cnt_reg <= sec_cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            slot_reg    <= slot_next;
            group_reg   <= group_next;
            served_reg  <= served_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accepted) begin
            item_reg <= s_item;
        end
        m_item_reg <= m_item_next;
    end

    // The read address follows the next head so the front entry is ready every cycle.
    tqwd_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (tail_reg),
        .wr_data (item_reg.vehicle_code),
        .rd_addr (head_next),
        .rd_data (ram_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: design/two_queue_weighted_dispatcher_unit.sv
// Top level of the two-queue weighted round-robin dispatcher.
// A booking word runs the fetch, decode and enqueue steps, and a dispatch word runs fetch,
// decode, batch setup, one slot step per served vehicle (at most 36, and a single slot step
// for an empty batch) from the slot step of the control program, and a closing step that
// emits the empty marker when nothing was served. The result register stalls the program
// only while m_ready is held low. Bookings whose class queue already holds QUEUE_DEPTH
// entries return a single dropped word.
module two_queue_weighted_dispatcher_unit #(
    parameter int QUEUE_DEPTH = tqwd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tqwd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tqwd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tqwd_pkg::in_item_t              s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tqwd_pkg::out_item_t             m_item
);

    tqwd_pkg::act_t       act;
    tqwd_pkg::dp_status_t status;

    tqwd_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .act     (act)
    );

    tqwd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .act       (act),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// File: design/tqwd_checker.sv
// Port-level checks of the dispatcher and their attachment to the top level.
module tqwd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input tqwd_pkg::out_item_t m_item
);

    // A word that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result word changed while stalled");

    // The empty marker carries code zero and closes its batch.
    a_empty_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == tqwd_pkg::KIND_EMPTY |->
            m_item.vehicle_code_res == 8'h00 && m_item.last)
        else $error("empty marker malformed");

    // A dropped booking is the only result of its word.
    a_drop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == tqwd_pkg::KIND_DROPPED |-> m_item.last)
        else $error("dropped booking without last");

    // The program decodes each accepted word before taking another.
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken in consecutive cycles");

endmodule

bind two_queue_weighted_dispatcher_unit tqwd_checker u_tqwd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// File: test/two_queue_weighted_dispatcher_unit_tb.sv
// Self-checking testbench for the two-queue weighted dispatcher: bookings, batches and drops.
module two_queue_weighted_dispatcher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = tqwd_pkg::QUEUE_DEPTH_DEFAULT;
    // Longest dispatch is 36 vehicles plus the fetch, decode, setup and closing steps; leave some margin.
    localparam int SETTLE_CYCLES = 50;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTED = 20;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [tqwd_pkg::CFG_IDX_W-1:0]  cfg_index = tqwd_pkg::REG_PPG;
    logic [tqwd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    tqwd_pkg::in_item_t              s_item = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    tqwd_pkg::out_item_t             m_item;

    two_queue_weighted_dispatcher_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow of the block: configuration, priority count and second-class line.
    logic [3:0]  seats_per_group = tqwd_pkg::PPG_RESET;
    logic [2:0]  groups_per_batch = tqwd_pkg::GPT_RESET;
    int unsigned prio_waiting = 0;
    logic [7:0]  coach_line[$];

    tqwd_pkg::in_item_t  pending_words[$];
    tqwd_pkg::out_item_t awaited_words[$];

    int unsigned mismatches = 0;
    int unsigned words_taken = 0;
    int unsigned vehicles_seen = 0;
    int unsigned markers_seen = 0;
    int unsigned drops_seen = 0;
    int unsigned settings_used = 1;

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    logic [7:0]  ready_mask = 8'hFF;
    logic [2:0]  ready_phase = '0;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic tqwd_pkg::out_item_t make_word(input logic [1:0] kind,
                                                      input logic [7:0] code);
        tqwd_pkg::out_item_t w;
        w.kind = kind;
        w.vehicle_code_res = code;
        w.last = 1'b0;
        return w;
    endfunction

    // Serve one slot of a group; an empty queue lends its slot to the other one.
    function automatic bit take_slot(input bit want_priority, output logic [7:0] code);
        code = 8'h00;
        if (want_priority && prio_waiting > 0) begin
            prio_waiting--;
            code = tqwd_pkg::PRIORITY_CODE;
            return 1'b1;
        end
        if (coach_line.size() > 0) begin
            code = coach_line.pop_front();
            return 1'b1;
        end
        if (prio_waiting > 0) begin
            prio_waiting--;
            code = tqwd_pkg::PRIORITY_CODE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void predict_results(input tqwd_pkg::in_item_t w);
        tqwd_pkg::out_item_t batch[$];
        tqwd_pkg::out_item_t r;
        int unsigned         seats;
        int unsigned         groups;
        logic [7:0]          code;
        if (w.func == tqwd_pkg::FUNC_BOOK) begin
            if (w.vehicle_code == tqwd_pkg::PRIORITY_CODE) begin
                if (prio_waiting >= DEPTH)
                    batch.insert(batch.size(),
                                 make_word(tqwd_pkg::KIND_DROPPED, w.vehicle_code));
                else
                    prio_waiting++;
            end else begin
                if (coach_line.size() >= DEPTH)
                    batch.insert(batch.size(),
                                 make_word(tqwd_pkg::KIND_DROPPED, w.vehicle_code));
                else
                    coach_line.insert(coach_line.size(), w.vehicle_code);
            end
        end else begin
            // Out-of-range register values saturate into the legal range.
            seats = (seats_per_group == 4'd0) ? 32'd1 :
                    (seats_per_group > tqwd_pkg::PPG_MAX) ? 32'(tqwd_pkg::PPG_MAX)
                                                          : 32'(seats_per_group);
            groups = (groups_per_batch == 3'd0) ? 32'd1 :
                     (groups_per_batch > tqwd_pkg::GPT_MAX) ? 32'(tqwd_pkg::GPT_MAX)
                                                            : 32'(groups_per_batch);
            for (int unsigned g = 0; g < groups; g++) begin
                for (int unsigned s = 0; s <= seats; s++) begin
                    if (take_slot(s < seats, code))
                        batch.insert(batch.size(),
                                     make_word(tqwd_pkg::KIND_VEHICLE, code));
                end
            end
            if (batch.size() == 0)
                batch.insert(batch.size(), make_word(tqwd_pkg::KIND_EMPTY, 8'h00));
        end
        foreach (batch[i]) begin
            r = batch[i];
            r.last = (i == batch.size() - 1);
            awaited_words.insert(awaited_words.size(), r);
        end
    endfunction

    // Sender: bursts of words separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_results(pending_words.pop_front());
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_valid <= 1'b1;
                    s_item <= pending_words[0];
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off, started partway into the random traffic.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && words_taken >= 80) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each word and stalls on an eight-bit ready pattern picked anew each round.
    always @(posedge aclk) begin
        tqwd_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                case (m_item.kind)
                    tqwd_pkg::KIND_VEHICLE: vehicles_seen++;
                    tqwd_pkg::KIND_EMPTY:   markers_seen++;
                    default:                drops_seen++;
                endcase
                if (awaited_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word kind=%0d code=%02h last=%0b",
                                              m_item.kind, m_item.vehicle_code_res,
                                              m_item.last));
                end else begin
                    want = awaited_words.pop_front();
                    if (m_item.kind !== want.kind ||
                        m_item.vehicle_code_res !== want.vehicle_code_res ||
                        m_item.last !== want.last)
                        report_mismatch($sformatf(
                            "got kind=%0d code=%02h last=%0b, want kind=%0d code=%02h last=%0b",
                            m_item.kind, m_item.vehicle_code_res, m_item.last,
                            want.kind, want.vehicle_code_res, want.last));
                end
            end
            if (ready_phase == 0) begin
                case ($urandom_range(0, 3))
                    0, 2:    ready_mask = 8'hFF;
                    1:       ready_mask = 8'($urandom_range(0, 255));
                    default: ready_mask = 8'h01;
                endcase
            end
            m_ready <= (hold_left == 0) && ready_mask[ready_phase];
            ready_phase <= ready_phase + 1'b1;
        end
    end

    task automatic set_registers(input logic [3:0] seats_val, input logic [3:0] groups_val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= tqwd_pkg::REG_PPG;
        cfg_wdata <= seats_val;
        @(posedge aclk);
        cfg_index <= tqwd_pkg::REG_GPT;
        cfg_wdata <= groups_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        seats_per_group = seats_val;
        groups_per_batch = groups_val[2:0];
        settings_used++;
        @(negedge aclk);
    endtask

    task automatic add_word(input logic func, input logic [7:0] code);
        tqwd_pkg::in_item_t w;
        w.func = func;
        w.vehicle_code = code;
        pending_words.insert(pending_words.size(), w);
    endtask

    function automatic logic [7:0] coach_code();
        logic [7:0] code;
        do
            code = 8'($urandom_range(0, 255));
        while (code == tqwd_pkg::PRIORITY_CODE);
        return code;
    endfunction

    // Mostly runs of bookings closed by a dispatch, with some loose words mixed in.
    task automatic random_traffic(input int unsigned count);
        int unsigned n;
        int unsigned k;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 8) begin
                k = $urandom_range(0, 10);
                repeat (k) begin
                    add_word(tqwd_pkg::FUNC_BOOK,
                             ($urandom_range(0, 2) == 0) ? tqwd_pkg::PRIORITY_CODE
                                                         : 8'($urandom_range(0, 255)));
                end
                add_word(tqwd_pkg::FUNC_DISPATCH, 8'($urandom_range(0, 255)));
                n += k + 1;
            end else begin
                add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                n++;
            end
        end
    endtask

    // The block is idle once all words are in, all results are out and it has settled.
    task automatic wait_idle();
        while (pending_words.size() > 0 || awaited_words.size() > 0 || s_valid)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: empty batch, a full batch with lending, an early end.
        add_word(tqwd_pkg::FUNC_DISPATCH, 8'h00);
        repeat (3) add_word(tqwd_pkg::FUNC_BOOK, tqwd_pkg::PRIORITY_CODE);
        add_word(tqwd_pkg::FUNC_BOOK, 8'h00);
        add_word(tqwd_pkg::FUNC_BOOK, 8'hFF);
        add_word(tqwd_pkg::FUNC_BOOK, 8'h55);
        add_word(tqwd_pkg::FUNC_BOOK, 8'hAA);
        repeat (3) add_word(tqwd_pkg::FUNC_BOOK, tqwd_pkg::PRIORITY_CODE);
        add_word(tqwd_pkg::FUNC_BOOK, 8'h42);
        add_word(tqwd_pkg::FUNC_BOOK, 8'h44);
        add_word(tqwd_pkg::FUNC_DISPATCH, 8'hFF);
        add_word(tqwd_pkg::FUNC_DISPATCH, 8'h00);
        add_word(tqwd_pkg::FUNC_DISPATCH, 8'h00);
        wait_idle();

        set_registers(4'd1, 4'd1);
        add_word(tqwd_pkg::FUNC_BOOK, tqwd_pkg::PRIORITY_CODE);
        add_word(tqwd_pkg::FUNC_BOOK, tqwd_pkg::PRIORITY_CODE);
        add_word(tqwd_pkg::FUNC_BOOK, 8'h10);
        add_word(tqwd_pkg::FUNC_DISPATCH, 8'h00);
        add_word(tqwd_pkg::FUNC_DISPATCH, 8'h00);
        add_word(tqwd_pkg::FUNC_DISPATCH, 8'h00);
        random_traffic(50);
        wait_idle();

        // Zero in both registers acts as one.
        set_registers(4'd0, 4'd0);
        random_traffic(50);
        wait_idle();

        set_registers(4'd15, 4'd7);
        random_traffic(50);
        wait_idle();

        // Overfill both queues so that bookings get dropped, then drain them.
        set_registers(tqwd_pkg::PPG_MAX, {1'b0, tqwd_pkg::GPT_MAX});
        repeat (DEPTH + 2) add_word(tqwd_pkg::FUNC_BOOK, coach_code());
        repeat (DEPTH + 2) add_word(tqwd_pkg::FUNC_BOOK, tqwd_pkg::PRIORITY_CODE);
        repeat (5) add_word(tqwd_pkg::FUNC_DISPATCH, 8'($urandom_range(0, 255)));
        wait_idle();

        // Bit 3 of the group count is beyond the register and is dropped.
        set_registers(4'd3, 4'b1010);
        random_traffic(50);
        wait_idle();

        set_registers(4'($urandom_range(1, 8)), 4'($urandom_range(1, 4)));
        random_traffic(50);
        wait_idle();

        if (awaited_words.size() > 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                                      awaited_words.size()));
        $display("Ran %0d input words over %0d register settings, with one long receiver stall.",
                 words_taken, settings_used);
        $display("Checked %0d vehicles, %0d empty-batch markers and %0d dropped bookings.",
                 vehicles_seen, markers_seen, drops_seen);
        if (mismatches == 0)
            $display("[two_queue_weighted_dispatcher_unit] OK");
        else
            $display("[two_queue_weighted_dispatcher_unit] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d words pending and %0d results outstanding.",
                 pending_words.size(), awaited_words.size());
        $display("[two_queue_weighted_dispatcher_unit] ERROR");
        $finish;
    end

endmodule
